>>> rtl/core/positional_list_engine_unit_macros.svh
// Assertion macros for the positional list engine.
// Used by positional_list_engine_unit; expects clk and rst in scope.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define PLE_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ple_pkg.sv
// Shared constants and helpers for the positional list engine.
// No dependencies.
`default_nettype none

package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = ((CNT_W > 7) ? CNT_W : 7) + 1;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] PLACE_AT    = 2'd0;
  localparam logic [1:0] PLACE_FRONT = 2'd1;
  localparam logic [1:0] PLACE_BACK  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef logic [DATA_WIDTH-1:0] data_t;

  // Sign-extend a stored entry and keep 32 bits for the result port.
  function automatic logic [31:0] to_read_field(input data_t v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    return w[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ple_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/positional_list_engine_unit.sv
// Positional list engine: ordered list of up to CAPACITY entries kept in one RAM.
// Depends on ple_pkg, ple_ram and positional_list_engine_unit_macros.svh.
//
// A request beat is taken when start is high and busy is low. Its result shows
// on status, read_value and count for exactly one cycle with done high; the
// receiver cannot stall, and a new request may be started in that same cycle.
// Flagged requests, a back insert and a delete of the last entry finish
// straight from idle; a read passes through S_RD for its registered RAM
// read. Other inserts and deletes first move the entries behind the position
// one per cycle through the single write port of the entry RAM.
`default_nettype none
`include "positional_list_engine_unit_macros.svh"

module positional_list_engine_unit
  import ple_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [1:0]  place,
  input  wire logic [6:0]  position,
  input  wire logic [31:0] value,
  output      logic        done,
  output      logic [1:0]  status,
  output      logic [31:0] read_value,
  output      logic [6:0]  count
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS     = 3'd1;
  localparam logic [2:0] S_INS_FIN = 3'd2;
  localparam logic [2:0] S_INS_PUT = 3'd3;
  localparam logic [2:0] S_DEL     = 3'd4;
  localparam logic [2:0] S_DEL_FIN = 3'd5;
  localparam logic [2:0] S_RD      = 3'd6;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] entries;
  logic [ADDR_W-1:0] rd_ptr, stop_ptr, wb_addr;
  logic             wb_pend;
  data_t            hold_data;

  logic             we;
  logic [ADDR_W-1:0] waddr, raddr;
  data_t            wdata, rdata;

  logic [POS_W-1:0] cnt_ext, pos, pos_m1, cnt_m1;
  logic [1:0]       dec_status;
  logic [ADDR_W-1:0] pos_idx, last_idx;
  logic             accept;

  ple_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign count  = 7'(entries);

  // Request decode
  always_comb begin
    cnt_ext = POS_W'(entries);
    cnt_m1  = cnt_ext - POS_W'(1);
    if (place == PLACE_FRONT) begin
      pos = POS_W'(1);
    end else if (place == PLACE_BACK) begin
      pos = (req_type == REQ_INSERT) ? cnt_ext + POS_W'(1) : cnt_ext;
    end else begin
      pos = POS_W'(position);
    end
    pos_m1   = pos - POS_W'(1);
    pos_idx  = pos_m1[ADDR_W-1:0];
    last_idx = cnt_m1[ADDR_W-1:0];

    priority if ((req_type != REQ_INSERT && req_type != REQ_DELETE &&
                  req_type != REQ_READ) ||
                 (place != PLACE_AT && place != PLACE_FRONT && place != PLACE_BACK)) begin
      dec_status = ST_BADPOS;
    end else if (req_type == REQ_INSERT) begin
      if (pos == '0 || pos > cnt_ext + POS_W'(1)) begin
        dec_status = ST_BADPOS;
      end else if (entries == CNT_W'(CAPACITY)) begin
        dec_status = ST_FULL;
      end else begin
        dec_status = ST_OK;
      end
    end else if (entries == '0) begin
      dec_status = ST_EMPTY;
    end else if (pos == '0 || pos > cnt_ext) begin
      dec_status = ST_BADPOS;
    end else begin
      dec_status = ST_OK;
    end
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = wb_addr;
    wdata = rdata;
    raddr = rd_ptr;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        raddr = pos_idx;
        if (accept && dec_status == ST_OK) begin
          if (req_type == REQ_INSERT) begin
            if (pos == cnt_ext + POS_W'(1)) begin
              we    = 1'b1;
              waddr = pos_idx;
              wdata = DATA_WIDTH'($unsigned(value));
            end else begin
              state_next = S_INS;
            end
          end else if (req_type == REQ_DELETE) begin
            if (pos != cnt_ext) begin
              state_next = S_DEL;
            end
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_INS: begin
        we = wb_pend;
        if (rd_ptr == stop_ptr) begin
          state_next = S_INS_FIN;
        end
      end
      S_INS_FIN: begin
        we = 1'b1;
        state_next = S_INS_PUT;
      end
      S_INS_PUT: begin
        we    = 1'b1;
        waddr = stop_ptr;
        wdata = hold_data;
        state_next = S_IDLE;
      end
      S_DEL: begin
        we = wb_pend;
        if (rd_ptr == last_idx) begin
          state_next = S_DEL_FIN;
        end
      end
      S_DEL_FIN: begin
        we = 1'b1;
        state_next = S_IDLE;
      end
      S_RD: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      entries <= '0;
      done    <= 1'b0;
      wb_pend <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          wb_pend <= 1'b0;
          if (accept) begin
            hold_data <= DATA_WIDTH'($unsigned(value));
            stop_ptr  <= pos_idx;
            if (req_type == REQ_INSERT) begin
              rd_ptr <= last_idx;
            end else begin
              rd_ptr <= pos[ADDR_W-1:0];
            end
            if (dec_status != ST_OK || state_next == S_IDLE) begin
              done       <= 1'b1;
              status     <= dec_status;
              read_value <= '0;
              if (dec_status == ST_OK) begin
                if (req_type == REQ_INSERT) begin
                  entries <= entries + CNT_W'(1);
                end else begin
                  entries <= entries - CNT_W'(1);
                end
              end
            end
          end
        end
        S_INS: begin
          wb_pend <= 1'b1;
          wb_addr <= rd_ptr + ADDR_W'(1);
          rd_ptr  <= rd_ptr - ADDR_W'(1);
        end
        S_INS_FIN: begin
          wb_pend <= 1'b0;
        end
        S_INS_PUT: begin
          entries    <= entries + CNT_W'(1);
          done       <= 1'b1;
          status     <= ST_OK;
          read_value <= '0;
        end
        S_DEL: begin
          wb_pend <= 1'b1;
          wb_addr <= rd_ptr - ADDR_W'(1);
          rd_ptr  <= rd_ptr + ADDR_W'(1);
        end
        S_DEL_FIN: begin
          wb_pend    <= 1'b0;
          entries    <= entries - CNT_W'(1);
          done       <= 1'b1;
          status     <= ST_OK;
          read_value <= '0;
        end
        S_RD: begin
          done       <= 1'b1;
          status     <= ST_OK;
          read_value <= to_read_field(rdata);
        end
        default: begin
          wb_pend <= 1'b0;
        end
      endcase
    end
  end

  `PLE_ASSERT(a_count_bound, entries <= CNT_W'(CAPACITY), "entry count above capacity")
  `PLE_ASSERT(a_done_idle, !done || !busy, "result beat while a request is in flight")
  `PLE_ASSERT(a_count_hold, done || $past(rst) || $stable(entries), "count moved without result")
  `PLE_ASSERT_NEXT(a_busy_no_start, busy && !done, !done || state == S_IDLE, "result outside idle")

endmodule

`default_nettype wire

>>> tb/ple_tb_pkg.sv
// Request codes that the testbench uses beyond those of ple_pkg.
// No dependencies; shared by the list monitor and the testbench top.
package ple_tb_pkg;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam logic [1:0] PLACE_UNUSED = 2'd3;

endpackage

>>> tb/positional_list_monitor.sv
// Monitor for the positional list engine: keeps a shadow copy of the list,
// predicts each result beat and compares it with the block's result ports.
// Depends on ple_pkg and ple_tb_pkg.
module positional_list_monitor
  import ple_pkg::*, ple_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type,
  input  logic [1:0]  place,
  input  logic [6:0]  position,
  input  logic [31:0] value,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [31:0] read_value,
  input  logic [6:0]  count,
  output int          failures,
  output int          pending,
  output int          occupancy,
  output int          results_checked,
  output int          full_seen,
  output int          empty_seen,
  output int          badpos_seen,
  output int          peak_len
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] rd;
    logic [6:0]  cnt;
  } list_result_t;

  data_t        shadow_list[$];
  list_result_t awaited_results[$];
  list_result_t want;

  initial begin
    failures        = 0;
    pending         = 0;
    occupancy       = 0;
    results_checked = 0;
    full_seen       = 0;
    empty_seen      = 0;
    badpos_seen     = 0;
    peak_len        = 0;
  end

  function automatic list_result_t apply_request(input logic [1:0] rq, input logic [1:0] pl,
                                                 input logic [6:0] gp, input logic [31:0] v);
    list_result_t r;
    int len;
    int slot;
    len      = shadow_list.size();
    r.status = ST_OK;
    r.rd     = '0;
    slot     = 0;
    if (rq == REQ_UNUSED || pl == PLACE_UNUSED) begin
      r.status = ST_BADPOS;
    end else if (rq == REQ_INSERT) begin
      slot = (pl == PLACE_FRONT) ? 1 : (pl == PLACE_BACK) ? len + 1 : int'(gp);
      if (slot < 1 || slot > len + 1) begin
        r.status = ST_BADPOS;
      end else if (len >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        shadow_list.insert(slot - 1, data_t'(v));
      end
    end else if (len == 0) begin
      r.status = ST_EMPTY;
    end else begin
      slot = (pl == PLACE_FRONT) ? 1 : (pl == PLACE_BACK) ? len : int'(gp);
      if (slot < 1 || slot > len) begin
        r.status = ST_BADPOS;
      end else if (rq == REQ_READ) begin
        r.rd = 32'(signed'(shadow_list[slot - 1]));
      end else begin
        shadow_list.delete(slot - 1);
      end
    end
    r.cnt = 7'(shadow_list.size());
    case (r.status)
      ST_FULL:   full_seen++;
      ST_EMPTY:  empty_seen++;
      ST_BADPOS: badpos_seen++;
      default:   ;
    endcase
    if (shadow_list.size() > peak_len) peak_len = shadow_list.size();
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      shadow_list.delete();
      awaited_results.delete();
    end else begin
      if (start && !busy) awaited_results.push_back(apply_request(req_type, place, position, value));
      if (done) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing outstanding: status %0d count %0d", status, count);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
          end
          if (read_value !== want.rd) begin
            $error("read_value: expected %h, actual %h", want.rd, read_value);
            failures++;
          end
          if (count !== want.cnt) begin
            $error("count: expected %0d, actual %0d", want.cnt, count);
            failures++;
          end
        end
      end
    end
    pending   = awaited_results.size();
    occupancy = shadow_list.size();
  end

endmodule

>>> tb/tb_positional_list_engine_unit.sv
// Testbench top for positional_list_engine_unit: directed and random requests
// with idle bursts; checking is done by positional_list_monitor.
// Depends on ple_pkg, ple_tb_pkg, positional_list_monitor and the block's RTL.
module tb_positional_list_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;
  import ple_tb_pkg::*;

  localparam int RANDOM_ITEMS = 650;
  localparam int QUIET_TAIL   = 120;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [1:0]  place;
  logic [6:0]  position;
  logic [31:0] value;
  logic        done;
  logic [1:0]  status;
  logic [31:0] read_value;
  logic [6:0]  count;

  int failures;
  int pending;
  int occupancy;
  int results_checked;
  int full_seen;
  int empty_seen;
  int badpos_seen;
  int peak_len;
  int cycle_cnt;

  positional_list_engine_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .place      (place),
    .position   (position),
    .value      (value),
    .done       (done),
    .status     (status),
    .read_value (read_value),
    .count      (count)
  );

  positional_list_monitor u_monitor (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .place           (place),
    .position        (position),
    .value           (value),
    .done            (done),
    .status          (status),
    .read_value      (read_value),
    .count           (count),
    .failures        (failures),
    .pending         (pending),
    .occupancy       (occupancy),
    .results_checked (results_checked),
    .full_seen       (full_seen),
    .empty_seen      (empty_seen),
    .badpos_seen     (badpos_seen),
    .peak_len        (peak_len)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic put_request(input logic [1:0] rq, input logic [1:0] pl,
                             input logic [6:0] ps, input logic [31:0] v);
    start    = 1'b1;
    req_type = rq;
    place    = pl;
    position = ps;
    value    = v;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          mode;
    int          churn_left;
    int          linger;
    int          pct;
    int          lim;
    logic [1:0]  rq;
    logic [1:0]  pl;
    logic [6:0]  ps;
    rst      = 1'b1;
    start    = 1'b0;
    req_type = REQ_INSERT;
    place    = PLACE_AT;
    position = '0;
    value    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty list, bounds, every place, extreme values, unused codes
    put_request(REQ_READ,   PLACE_FRONT, 7'd0,   32'h0);
    put_request(REQ_DELETE, PLACE_BACK,  7'd0,   32'h0);
    put_request(REQ_READ,   PLACE_AT,    7'd0,   32'h0);
    put_request(REQ_INSERT, PLACE_AT,    7'd0,   32'h1234_5678);
    put_request(REQ_INSERT, PLACE_AT,    7'd2,   32'h1234_5678);
    put_request(REQ_INSERT, PLACE_AT,    7'd1,   32'h7fff_ffff);
    put_request(REQ_INSERT, PLACE_FRONT, 7'd127, 32'h8000_0000);
    put_request(REQ_INSERT, PLACE_BACK,  7'd0,   32'h0);
    put_request(REQ_INSERT, PLACE_AT,    7'd4,   32'hffff_ffff);
    put_request(REQ_INSERT, PLACE_AT,    7'd2,   $urandom);
    put_request(REQ_READ,   PLACE_FRONT, 7'd0,   32'h0);
    put_request(REQ_READ,   PLACE_BACK,  7'd0,   32'h0);
    put_request(REQ_READ,   PLACE_AT,    7'd3,   32'h0);
    put_request(REQ_READ,   PLACE_AT,    7'd127, 32'h0);
    put_request(REQ_READ,   PLACE_AT,    7'd0,   32'h0);
    put_request(REQ_UNUSED, PLACE_FRONT, 7'd1,   32'hffff_ffff);
    put_request(REQ_INSERT, PLACE_UNUSED, 7'd1,  32'h5555_aaaa);
    put_request(REQ_DELETE, PLACE_AT,    7'd2,   32'h0);
    put_request(REQ_DELETE, PLACE_AT,    7'd6,   32'h0);
    put_request(REQ_DELETE, PLACE_FRONT, 7'd0,   32'h0);
    put_request(REQ_DELETE, PLACE_BACK,  7'd0,   32'h0);
    put_request(REQ_READ,   PLACE_AT,    7'd2,   32'h0);
    put_request(REQ_INSERT, PLACE_AT,    7'd127, 32'h0);
    put_request(REQ_DELETE, PLACE_AT,    7'd1,   32'h0);
    put_request(REQ_DELETE, PLACE_AT,    7'd1,   32'h0);

    // random: fill to full, churn, drain to empty, churn, and around again
    mode       = 0;
    churn_left = 0;
    linger     = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pct = $urandom_range(0, 99);
      case (mode)
        0:       rq = (pct < 70) ? REQ_INSERT : (pct < 85) ? REQ_DELETE : REQ_READ;
        2:       rq = (pct < 70) ? REQ_DELETE : (pct < 85) ? REQ_INSERT : REQ_READ;
        default: rq = (pct < 35) ? REQ_INSERT : (pct < 65) ? REQ_DELETE : REQ_READ;
      endcase
      if ($urandom_range(0, 32) == 0) rq = REQ_UNUSED;
      pct = $urandom_range(0, 19);
      pl = (pct == 0) ? PLACE_UNUSED : (pct < 5) ? PLACE_FRONT : (pct < 9) ? PLACE_BACK : PLACE_AT;
      lim = (rq == REQ_INSERT) ? occupancy + 1 : occupancy;
      if ($urandom_range(0, 6) == 0) ps = 7'($urandom_range(0, 127));
      else ps = 7'($urandom_range(0, lim + 1));
      put_request(rq, pl, ps, pick_value());

      case (mode)
        0: begin
          if (occupancy == CAPACITY) linger++;
          if (linger > 4) begin
            mode       = 1;
            linger     = 0;
            churn_left = 40;
          end
        end
        2: begin
          if (occupancy == 0) linger++;
          if (linger > 4) begin
            mode       = 3;
            linger     = 0;
            churn_left = 40;
          end
        end
        default: begin
          churn_left--;
          if (churn_left <= 0) mode = (mode + 1) % 4;
        end
      endcase

      if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
        hold_off($urandom_range(1, 14));
    end
    start = 1'b0;

    wait (pending == 0);
    repeat (80) @(posedge clk);

    $display("checked %0d result beats; peak list length %0d of %0d", results_checked,
             peak_len, CAPACITY);
    $display("flagged results: %0d list full, %0d list empty, %0d invalid position",
             full_seen, empty_seen, badpos_seen);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ple_pkg.sv
rtl/core/ple_ram.sv
rtl/core/positional_list_engine_unit.sv
tb/ple_tb_pkg.sv
tb/positional_list_monitor.sv
tb/tb_positional_list_engine_unit.sv
